[sv/bskt_pkg.sv]
// Package for the bucketed sorted key table.
// Holds field widths, parameter defaults, item structs and sequencer codes.
// No dependencies; used by bucketed_sorted_key_table_top and the testbench.
package bskt_pkg;

    // Fixed widths of the transfer fields.
    localparam int BUCKET_FIELD_W = 8;
    localparam int KEY_FIELD_W    = 64;
    localparam int PAY_FIELD_W    = 64;
    localparam int TOTAL_W        = 13;

    // Default values of the top-level parameters.
    localparam int BUCKET_BITS_DEF  = 8;
    localparam int BUCKET_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Request modes.
    typedef enum logic [1:0] {
        MODE_FIND     = 2'd0,
        MODE_INSERT   = 2'd1,
        MODE_FIND_INS = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    // One request transfer.
    typedef struct packed {
        mode_t                     mode;
        logic [BUCKET_FIELD_W-1:0] bucket;
        logic [KEY_FIELD_W-1:0]    key_rest;
        logic [PAY_FIELD_W-1:0]    payload;
    } req_item_t;

    // One response transfer.
    typedef struct packed {
        logic                   found;
        logic [PAY_FIELD_W-1:0] stored_payload;
        logic                   inserted;
        logic                   full_res;
        logic [TOTAL_W-1:0]     total_count;
    } rsp_item_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_LOAD,
        S_SEARCH,
        S_CMP,
        S_MATCH,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

[sv/bucketed_sorted_key_table_top.sv]
// Top level of the bucketed sorted key table: sequencer, shared key
// comparator, count memory and entry memory.
// Depends on bskt_pkg.
//
// Usage: a request transfer on req (valid/stall) carries a mode, a bucket,
// a key and a payload; one response transfer on rsp follows for each.
// Only one request is worked on at a time: req_stall is low only while the
// sequencer is idle, so a new request waits until the last response is loaded.
// One entry memory port (one read, one write per cycle) and one key
// comparator do all the work.
// Steps of each request, in order:
//   find:   read the bucket's entry count, then a binary search with one read
//           and one compare per search step, then the match check,
//   insert: the find steps, then, if the bucket has room, a read and a write
//           per entry moved up by one slot and the write of the new entry,
//   clear:  one count entry zeroed per cycle.
// Reset starts a clearing pass over the count memory during which no request
// is taken. The response sits in an output register that holds while the
// receiver stalls.
module bucketed_sorted_key_table_top #(
    parameter int BUCKET_BITS  = bskt_pkg::BUCKET_BITS_DEF,
    parameter int BUCKET_DEPTH = bskt_pkg::BUCKET_DEPTH_DEF,
    parameter int KEY_BITS     = bskt_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = bskt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bskt_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bskt_pkg::rsp_item_t rsp
);

    localparam int IDX_W       = $clog2(BUCKET_DEPTH);
    localparam int CNT_W       = $clog2(BUCKET_DEPTH + 1);
    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int ADDR_W      = BUCKET_BITS + IDX_W;
    localparam int ENT_W       = KEY_BITS + PAYLOAD_BITS;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUCKET_DEPTH);

    // Registers.
    bskt_pkg::state_t    state_reg, state_next;
    bskt_pkg::req_item_t item_reg, item_next;
    logic [BUCKET_BITS-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                         clr_item_reg, clr_item_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             lo_reg, lo_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic                         found_reg, found_next;
    logic [PAYLOAD_BITS-1:0]      spay_reg, spay_next;
    logic                         ins_reg, ins_next;
    logic                         full_reg, full_next;
    logic [bskt_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                         out_valid_reg, out_valid_next;
    bskt_pkg::rsp_item_t          out_data_reg, out_data_next;

    // Memories and their ports.
    logic [ENT_W-1:0] ent_mem [1 << ADDR_W];
    logic [CNT_W-1:0] cnt_mem [NUM_BUCKETS];
    logic [ENT_W-1:0] ent_rdata_reg;
    logic [CNT_W-1:0] cnt_rdata_reg;
    logic             ent_we;
    logic [ADDR_W-1:0] ent_wa;
    logic [ADDR_W-1:0] ent_ra;
    logic [ENT_W-1:0] ent_wd;
    logic             cnt_we;
    logic [BUCKET_BITS-1:0] cnt_wa;
    logic [CNT_W-1:0] cnt_wd;

    // Working values derived from the held request.
    logic [BUCKET_BITS-1:0]  bidx;
    logic [BUCKET_BITS-1:0]  req_bidx;
    logic [KEY_BITS-1:0]     key_w;
    logic [PAYLOAD_BITS-1:0] pay_w;
    logic [KEY_BITS-1:0]     key_rd;
    logic [PAYLOAD_BITS-1:0] pay_rd;
    logic [CNT_W-1:0]        half;
    logic [CNT_W-1:0]        mid;
    logic                    key_less;
    logic                    found_now;
    logic                    want_ins;
    logic                    out_free;
    logic                    accept;

    // Slot below a given position, cut to the slot index width.
    function automatic logic [IDX_W-1:0] idx_next_addr(input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] below;
        below = pos - CNT_W'(1);
        return below[IDX_W-1:0];
    endfunction

    assign bidx     = BUCKET_BITS'(item_reg.bucket);
    assign req_bidx = BUCKET_BITS'(req.bucket);
    assign key_w    = KEY_BITS'(item_reg.key_rest);
    assign pay_w    = PAYLOAD_BITS'(item_reg.payload);
    assign key_rd   = ent_rdata_reg[ENT_W-1 -: KEY_BITS];
    assign pay_rd   = ent_rdata_reg[PAYLOAD_BITS-1:0];
    assign half     = n_reg >> 1;
    assign mid      = lo_reg + half;

    // The shared comparator: the stored key against the request key.
    assign key_less  = key_rd < key_w;
    assign found_now = (lo_reg < cnt_reg) && (key_rd == key_w);
    assign want_ins  = (item_reg.mode == bskt_pkg::MODE_INSERT)
                    || ((item_reg.mode == bskt_pkg::MODE_FIND_INS) && !found_now);

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != bskt_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bskt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.mode == bskt_pkg::MODE_CLEAR) ? bskt_pkg::S_CLEAR
                                                                    : bskt_pkg::S_LOAD;
                end
            end
            bskt_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == {BUCKET_BITS{1'b1}})
                begin
                    state_next = clr_item_reg ? bskt_pkg::S_DONE : bskt_pkg::S_IDLE;
                end
            end
            bskt_pkg::S_LOAD:     state_next = bskt_pkg::S_SEARCH;
            bskt_pkg::S_SEARCH:
            begin
                state_next = (n_reg == '0) ? bskt_pkg::S_MATCH : bskt_pkg::S_CMP;
            end
            bskt_pkg::S_CMP:      state_next = bskt_pkg::S_SEARCH;
            bskt_pkg::S_MATCH:
            begin
                if (!want_ins || (cnt_reg == DEPTH_C))
                begin
                    state_next = bskt_pkg::S_DONE;
                end
                else
                begin
                    state_next = bskt_pkg::S_SHIFT_RD;
                end
            end
            bskt_pkg::S_SHIFT_RD:
            begin
                state_next = (idx_reg == lo_reg) ? bskt_pkg::S_WRITE : bskt_pkg::S_SHIFT_WR;
            end
            bskt_pkg::S_SHIFT_WR: state_next = bskt_pkg::S_SHIFT_RD;
            bskt_pkg::S_WRITE:    state_next = bskt_pkg::S_DONE;
            bskt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bskt_pkg::S_IDLE;
                end
            end
            default:              state_next = bskt_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb
    begin
        item_next      = item_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_item_next  = clr_item_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        spay_next      = spay_reg;
        ins_next       = ins_reg;
        full_next      = full_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_data_next  = out_data_reg;
        ent_we         = 1'b0;
        ent_wa         = {bidx, idx_reg[IDX_W-1:0]};
        ent_wd         = ent_rdata_reg;
        ent_ra         = {bidx, lo_reg[IDX_W-1:0]};
        cnt_we         = 1'b0;
        cnt_wa         = bidx;
        cnt_wd         = cnt_reg + CNT_W'(1);
        unique case (state_reg)
            bskt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req;
                    found_next = 1'b0;
                    spay_next  = '0;
                    ins_next   = 1'b0;
                    full_next  = 1'b0;
                    if (req.mode == bskt_pkg::MODE_CLEAR)
                    begin
                        total_next    = '0;
                        clr_cnt_next  = '0;
                        clr_item_next = 1'b1;
                    end
                end
            end
            bskt_pkg::S_CLEAR:
            begin
                cnt_we       = 1'b1;
                cnt_wa       = clr_cnt_reg;
                cnt_wd       = '0;
                clr_cnt_next = clr_cnt_reg + BUCKET_BITS'(1);
            end
            bskt_pkg::S_LOAD:
            begin
                cnt_next = cnt_rdata_reg;
                lo_next  = '0;
                n_next   = cnt_rdata_reg;
            end
            bskt_pkg::S_SEARCH:
            begin
                // Probe the middle entry, or the lower bound once the range is empty.
                if (n_reg != '0)
                begin
                    ent_ra = {bidx, mid[IDX_W-1:0]};
                end
            end
            bskt_pkg::S_CMP:
            begin
                if (key_less)
                begin
                    lo_next = mid + CNT_W'(1);
                    n_next  = n_reg - half - CNT_W'(1);
                end
                else
                begin
                    n_next = half;
                end
            end
            bskt_pkg::S_MATCH:
            begin
                if (found_now)
                begin
                    found_next = 1'b1;
                    spay_next  = pay_rd;
                end
                full_next = want_ins && (cnt_reg == DEPTH_C);
                idx_next  = cnt_reg;
            end
            bskt_pkg::S_SHIFT_RD:
            begin
                ent_ra = {bidx, idx_next_addr(idx_reg)};
            end
            bskt_pkg::S_SHIFT_WR:
            begin
                // Move the entry read last cycle up by one slot.
                ent_we   = 1'b1;
                idx_next = idx_reg - CNT_W'(1);
            end
            bskt_pkg::S_WRITE:
            begin
                ent_we     = 1'b1;
                ent_wa     = {bidx, lo_reg[IDX_W-1:0]};
                ent_wd     = {key_w, pay_w};
                cnt_we     = 1'b1;
                total_next = total_reg + bskt_pkg::TOTAL_W'(1);
                ins_next   = 1'b1;
            end
            bskt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.found          = found_reg;
                    out_data_next.stored_payload = bskt_pkg::PAY_FIELD_W'(spay_reg);
                    out_data_next.inserted       = ins_reg;
                    out_data_next.full_res       = full_reg;
                    out_data_next.total_count    = total_reg;
                    clr_item_next                = 1'b0;
                end
            end
            default:
            begin
                item_next = item_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bskt_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_item_reg  <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_item_reg  <= clr_item_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cnt_reg      <= cnt_next;
        lo_reg       <= lo_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        spay_reg     <= spay_next;
        ins_reg      <= ins_next;
        full_reg     <= full_next;
        out_data_reg <= out_data_next;
    end

    // Entry memory: key and payload side by side, registered read.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        ent_rdata_reg <= ent_mem[ent_ra];
    end

    // Count memory: read at the request's bucket as it is taken.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rdata_reg <= cnt_mem[req_bidx];
    end

    // A new response is loaded only from the done state.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && rsp_stall))
            |-> ($past(state_reg) == bskt_pkg::S_DONE))
        else $error("response loaded outside the done state");

    // An entry is written only into a bucket that still has room.
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bskt_pkg::S_WRITE) |-> (cnt_reg < DEPTH_C))
        else $error("insert into a full bucket");

    // A response never reports both an insert and a refusal.
    a_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.inserted && out_data_reg.full_res))
        else $error("inserted and full both set");

    // The search range never runs past the bucket's entry count.
    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == bskt_pkg::S_SEARCH) || (state_reg == bskt_pkg::S_CMP))
            |-> ((lo_reg + n_reg) <= cnt_reg))
        else $error("search range exceeds entry count");

endmodule

[tb/testbench.sv]
// Self-checking testbench for bucketed_sorted_key_table_top.
// Depends on bskt_pkg and the top module; a shadow table predicts every response,
// and directed plus random request streams run under random idling on both sides.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_BUCKETS = 1 << bskt_pkg::BUCKET_BITS_DEF;
    localparam int DEPTH       = bskt_pkg::BUCKET_DEPTH_DEF;
    localparam int IDLE_PCT    = 26;
    localparam int RANDOM_REQS = 424;
    localparam int DRAIN_CYCLES = 60;

    // Shadow copy of the table: sorted entries per bucket and the running total.
    class key_table_shadow;
        logic [bskt_pkg::KEY_FIELD_W-1:0] key_mem [NUM_BUCKETS][DEPTH];
        logic [bskt_pkg::PAY_FIELD_W-1:0] pay_mem [NUM_BUCKETS][DEPTH];
        int unsigned                      fill [NUM_BUCKETS];
        int unsigned                      held;
        bskt_pkg::rsp_item_t              pending_results [$];
        int unsigned                      mismatch_count;

        function new();
            foreach (fill[i])
                fill[i] = 0;
            held = 0;
            mismatch_count = 0;
        endfunction

        // Apply one accepted request and queue the response it must produce.
        function void apply_request(bskt_pkg::req_item_t item);
            bskt_pkg::rsp_item_t exp_rsp;
            int unsigned b;
            int unsigned n;
            int unsigned pos;
            int unsigned i;
            logic        want_insert;
            exp_rsp = '0;
            if (item.mode == bskt_pkg::MODE_CLEAR)
            begin
                foreach (fill[j])
                    fill[j] = 0;
                held = 0;
            end
            else
            begin
                b   = item.bucket;
                n   = fill[b];
                pos = 0;
                // Lower bound: first entry whose key is not below the request key.
                while (pos < n && key_mem[b][pos] < item.key_rest)
                    pos++;
                if (pos < n && key_mem[b][pos] == item.key_rest)
                begin
                    exp_rsp.found          = 1'b1;
                    exp_rsp.stored_payload = pay_mem[b][pos];
                end
                want_insert = (item.mode == bskt_pkg::MODE_INSERT) ||
                              (item.mode == bskt_pkg::MODE_FIND_INS && !exp_rsp.found);
                if (want_insert)
                begin
                    if (n >= DEPTH)
                    begin
                        exp_rsp.full_res = 1'b1;
                    end
                    else
                    begin
                        for (i = n; i > pos; i--)
                        begin
                            key_mem[b][i] = key_mem[b][i-1];
                            pay_mem[b][i] = pay_mem[b][i-1];
                        end
                        key_mem[b][pos]  = item.key_rest;
                        pay_mem[b][pos]  = item.payload;
                        fill[b]          = n + 1;
                        held++;
                        exp_rsp.inserted = 1'b1;
                    end
                end
            end
            exp_rsp.total_count = bskt_pkg::TOTAL_W'(held);
            pending_results = {pending_results, exp_rsp};
        endfunction

        // Compare one accepted response against the oldest queued one.
        function void compare_response(bskt_pkg::rsp_item_t got);
            bskt_pkg::rsp_item_t exp_rsp;
            if (pending_results.size() == 0)
            begin
                $error("response transfer with no request outstanding");
                mismatch_count++;
                return;
            end
            exp_rsp = pending_results.pop_front();
            if (got.found !== exp_rsp.found)
            begin
                $error("found: expected %0d, actual %0d", exp_rsp.found, got.found);
                mismatch_count++;
            end
            if (got.stored_payload !== exp_rsp.stored_payload)
            begin
                $error("stored_payload: expected %h, actual %h",
                       exp_rsp.stored_payload, got.stored_payload);
                mismatch_count++;
            end
            if (got.inserted !== exp_rsp.inserted)
            begin
                $error("inserted: expected %0d, actual %0d", exp_rsp.inserted, got.inserted);
                mismatch_count++;
            end
            if (got.full_res !== exp_rsp.full_res)
            begin
                $error("full_res: expected %0d, actual %0d", exp_rsp.full_res, got.full_res);
                mismatch_count++;
            end
            if (got.total_count !== exp_rsp.total_count)
            begin
                $error("total_count: expected %0d, actual %0d",
                       exp_rsp.total_count, got.total_count);
                mismatch_count++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    bskt_pkg::req_item_t req;
    logic                rsp_valid;
    logic                rsp_stall;
    bskt_pkg::rsp_item_t rsp;

    // While set, neither side idles.
    bit        calm;

    key_table_shadow                  table_shadow;
    logic [bskt_pkg::KEY_FIELD_W-1:0] key_pool [8];
    logic [7:0]                       hot_bucket [2];

    bucketed_sorted_key_table_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Present one request, with a random gap first, and hold it until the transfer.
    task automatic present_request(input bskt_pkg::mode_t mode, input logic [7:0] bucket,
                                   input logic [63:0] key_rest, input logic [63:0] payload);
        bskt_pkg::req_item_t item;
        item.mode     = mode;
        item.bucket   = bucket;
        item.key_rest = key_rest;
        item.payload  = payload;
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req       = item;
        do
            @(posedge clk);
        while (req_stall);
        table_shadow.apply_request(item);
    endtask

    // Receiver: random stalls, and every accepted response goes to the checker.
    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_stall = !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            table_shadow.compare_response(rsp);
    end

    // Main sequence: reset, directed requests, random requests, drain.
    initial
    begin
        bskt_pkg::mode_t mode;
        logic [7:0]      bucket;
        logic [63:0]     key_rest;
        int unsigned     pick;
        table_shadow = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        calm      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty bucket, key and payload extremes, duplicates at the lower bound.
        present_request(bskt_pkg::MODE_FIND,     8'h00, 64'h0, 64'h0);
        present_request(bskt_pkg::MODE_INSERT,   8'h00, '1, '1);
        present_request(bskt_pkg::MODE_INSERT,   8'h00, 64'h0, 64'h0);
        present_request(bskt_pkg::MODE_INSERT,   8'h00, '1, 64'h5555_5555_5555_5555);
        present_request(bskt_pkg::MODE_FIND,     8'h00, '1, 64'h0);
        // Find or insert with a match writes nothing; without one it inserts.
        present_request(bskt_pkg::MODE_FIND_INS, 8'h00, 64'h0, 64'h1234);
        present_request(bskt_pkg::MODE_FIND_INS, 8'hFF, 64'h8000_0000_0000_0001,
                        64'hAAAA_AAAA_AAAA_AAAA);
        present_request(bskt_pkg::MODE_FIND,     8'hFF, 64'h8000_0000_0000_0001, 64'h0);
        // Fill bucket zero with descending keys so each insert shifts the most.
        for (int k = 0; k < DEPTH - 3; k++)
            present_request(bskt_pkg::MODE_INSERT, 8'h00, 64'h7000_0000_0000_0000 - 64'(k),
                            {$urandom, $urandom});
        // Full bucket refuses inserts but still reports a match.
        present_request(bskt_pkg::MODE_INSERT,   8'h00, 64'h42, 64'h1);
        present_request(bskt_pkg::MODE_FIND_INS, 8'h00, 64'h43, 64'h2);
        present_request(bskt_pkg::MODE_FIND_INS, 8'h00, 64'h0, 64'h3);
        present_request(bskt_pkg::MODE_CLEAR,    8'h00, '1, '1);
        present_request(bskt_pkg::MODE_FIND,     8'h00, '1, 64'h0);

        // Random part: two hot buckets and a small key pool so buckets fill
        // and keys repeat, with some fully random buckets and keys mixed in.
        key_pool[0] = 64'h0;
        key_pool[1] = '1;
        for (int k = 2; k < 8; k++)
            key_pool[k] = {$urandom, $urandom};
        hot_bucket[0] = 8'($urandom);
        hot_bucket[1] = 8'($urandom);
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            calm = (n >= 200 && n < 280);
            pick = $urandom_range(99);
            if (pick < 1)
                mode = bskt_pkg::MODE_CLEAR;
            else if (pick < 31)
                mode = bskt_pkg::MODE_FIND;
            else if (pick < 66)
                mode = bskt_pkg::MODE_INSERT;
            else
                mode = bskt_pkg::MODE_FIND_INS;
            if ($urandom_range(99) < 75)
                bucket = hot_bucket[1'($urandom_range(1))];
            else
                bucket = 8'($urandom);
            if ($urandom_range(99) < 60)
                key_rest = key_pool[3'($urandom_range(7))];
            else
                key_rest = {$urandom, $urandom};
            present_request(mode, bucket, key_rest, {$urandom, $urandom});
        end
        calm = 1'b0;
        @(negedge clk);
        req_valid = 1'b0;

        while (table_shadow.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_shadow.mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
